// ----- hdl/dmfm_pkg.sv -----
// Shared types and constants for the dual-mode frequency meter.
// Used by dual_mode_frequency_meter and its bound port checker; depends on nothing.
package dmfm_pkg;

	// Register file
	localparam int CFG_W  = 16;
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_SWITCH   = 2'd0;
	localparam logic [1:0] REG_MIN_GATE = 2'd1;
	localparam logic [1:0] REG_MAX_GATE = 2'd2;
	localparam logic [CFG_W-1:0] SWITCH_RST   = 16'd300;
	localparam logic [CFG_W-1:0] MIN_GATE_RST = 16'd100;
	localparam logic [CFG_W-1:0] MAX_GATE_RST = 16'd500;

	// Result format
	localparam int Q8_W = 28;
	localparam logic [Q8_W-1:0] Q8_MAX    = 28'hFFF_FFFF;
	localparam logic [Q8_W-1:0] ONE_HZ_Q8 = 28'd256;

	// Divider: 34-bit dividend, 32-bit divisor, one quotient bit per cycle
	localparam int DIVD_W   = 34;
	localparam int DIVS_W   = 32;
	localparam int DCNT_W   = 6;
	localparam logic [DCNT_W-1:0] DIV_LAST = 6'd33;
	localparam logic [DIVD_W-1:0] PERIOD_NUM = 34'd256000000;
	localparam logic [17:0] GATE_SCALE = 18'd256000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_FILT,
		ST_OUT
	} state_t;

endpackage

// ----- hdl/dual_mode_frequency_meter.sv -----
// Dual-mode frequency meter: reciprocal period method and gated edge counting,
// with a jump filter. Depends on dmfm_pkg (constants, state type).
//
//  channel  | direction | word contents (lowest bit first)
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: period[31:0], now_ms[63:32], edge_count[79:64]
//  m_axis   | out       | tdata: freq_hz_q8[27:0], zero[31:28];
//           |           | tuser: held[0], gate_mode[1]
//  apb      | cfg       | 0x0 switch_period, 0x4 min_gate_ms, 0x8 max_gate_ms
//
// A divided word goes from acceptance to the result register through setup,
// 34 divider steps (one quotient bit each), filter and load. A stored value
// (zero period, gate overage) skips divider and filter, a filtered cache only
// the divider. s_tready is high only while the sequencer is idle; a stalled
// result waits in the output register and the sequencer holds in its load state.
// arst_n clears control state, config registers and meter state to reset values.
module dual_mode_frequency_meter (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // period[31:0], now_ms[63:32], edge_count[79:64]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // freq_hz_q8[27:0], zero padding[31:28]
	output logic [1:0]  m_tuser,   // held[0], gate_mode[1]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [dmfm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [dmfm_pkg::CFG_W-1:0] switch_q, min_gate_q, max_gate_q;
	logic                       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_q   <= dmfm_pkg::SWITCH_RST;
			min_gate_q <= dmfm_pkg::MIN_GATE_RST;
			max_gate_q <= dmfm_pkg::MAX_GATE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				dmfm_pkg::REG_SWITCH:   switch_q   <= pwdata[dmfm_pkg::CFG_W-1:0];
				dmfm_pkg::REG_MIN_GATE: min_gate_q <= pwdata[dmfm_pkg::CFG_W-1:0];
				dmfm_pkg::REG_MAX_GATE: max_gate_q <= pwdata[dmfm_pkg::CFG_W-1:0];
				default: ; // unmapped address: drop the write
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			dmfm_pkg::REG_SWITCH:   prdata = {16'd0, switch_q};
			dmfm_pkg::REG_MIN_GATE: prdata = {16'd0, min_gate_q};
			dmfm_pkg::REG_MAX_GATE: prdata = {16'd0, max_gate_q};
			default:                prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state and captured input word
	// ------------------------------------------------------------------
	dmfm_pkg::state_t state_q, state_d;

	logic [31:0] period_q;
	logic [31:0] now_q;
	logic [15:0] cnt_q;

	// meter state
	logic [dmfm_pkg::Q8_W-1:0] good_freq_q;
	logic [dmfm_pkg::Q8_W-1:0] cached_q;
	logic [31:0]               gate_ms_q;
	logic [15:0]               gate_cnt_q;

	// divider
	logic [dmfm_pkg::DIVD_W-1:0] num_q;   // dividend, shifts into quotient
	logic [dmfm_pkg::DIVS_W-1:0] rem_q;
	logic [dmfm_pkg::DIVS_W-1:0] den_q;
	logic [dmfm_pkg::DCNT_W-1:0] dcnt_q;
	logic                        gate_div_q; // quotient refreshes the gate count

	// pending result
	logic [dmfm_pkg::Q8_W-1:0] res_q;
	logic                      held_q;
	logic                      mode_q;

	// output register
	logic                      m_valid_q;
	logic [dmfm_pkg::Q8_W-1:0] m_freq_q;
	logic                      m_held_q;
	logic                      m_mode_q;

	// ------------------------------------------------------------------
	// Setup-cycle decisions (ST_CALC)
	// ------------------------------------------------------------------
	logic        period_mode;
	logic        period_zero;
	logic [31:0] elapsed;
	logic        gate_over;
	logic        gate_ready;
	logic [15:0] edges;
	logic [33:0] gate_num;
	logic        calc_to_div;
	logic        calc_to_out;

	assign period_mode = period_q >= {16'd0, switch_q};
	assign period_zero = period_q == 32'd0;
	assign elapsed     = now_q - gate_ms_q;
	assign gate_over   = elapsed > {16'd0, max_gate_q};
	assign gate_ready  = (elapsed >= {16'd0, min_gate_q}) && (elapsed != 32'd0);
	assign edges       = cnt_q - gate_cnt_q;
	assign gate_num    = {18'd0, edges} * {16'd0, dmfm_pkg::GATE_SCALE};

	// results that skip divider and filter: zero period, gate overage
	assign calc_to_out = period_mode ? period_zero : gate_over;
	// divide for a reciprocal period or a finished gate
	assign calc_to_div = period_mode ? !period_zero : (!gate_over && gate_ready);

	// ------------------------------------------------------------------
	// Divider step: restoring, one quotient bit per cycle
	// ------------------------------------------------------------------
	logic [dmfm_pkg::DIVS_W:0]   trial;
	logic [dmfm_pkg::DIVS_W:0]   trial_diff;
	logic                        qbit;

	assign trial      = {rem_q, num_q[dmfm_pkg::DIVD_W-1]};
	assign trial_diff = trial - {1'b0, den_q};
	assign qbit       = trial >= {1'b0, den_q};

	// ------------------------------------------------------------------
	// Jump filter (ST_FILT)
	// ------------------------------------------------------------------
	logic [dmfm_pkg::Q8_W-1:0] quot_sat;
	logic [dmfm_pkg::Q8_W-1:0] cand;
	logic [29:0]               cand2, cand3, last2, last3;
	logic                      both_live;
	logic                      jump;
	logic                      cand_live;

	// gate counts above the Q.8 range clamp to full scale
	assign quot_sat  = (num_q[dmfm_pkg::DIVD_W-1:dmfm_pkg::Q8_W] != '0) ? dmfm_pkg::Q8_MAX
	                 : num_q[dmfm_pkg::Q8_W-1:0];
	assign cand      = gate_div_q || mode_q == 1'b0 ? quot_sat : res_q;
	assign cand2     = {1'b0, cand, 1'b0};
	assign cand3     = {2'b00, cand} + {1'b0, cand, 1'b0};
	assign last2     = {1'b0, good_freq_q, 1'b0};
	assign last3     = {2'b00, good_freq_q} + {1'b0, good_freq_q, 1'b0};
	assign cand_live = cand > dmfm_pkg::ONE_HZ_Q8;
	assign both_live = cand_live && (good_freq_q > dmfm_pkg::ONE_HZ_Q8);
	// reject a rise above 3/2 or a fall below 2/3 of the last good value
	assign jump      = both_live && ((cand2 > last3) || (cand3 < last2));

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	logic out_free;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dmfm_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = dmfm_pkg::ST_CALC;
			end
			dmfm_pkg::ST_CALC: begin
				if (calc_to_out)      state_d = dmfm_pkg::ST_OUT;
				else if (calc_to_div) state_d = dmfm_pkg::ST_DIV;
				else                  state_d = dmfm_pkg::ST_FILT;
			end
			dmfm_pkg::ST_DIV: begin
				if (dcnt_q == '0) state_d = dmfm_pkg::ST_FILT;
			end
			dmfm_pkg::ST_FILT: state_d = dmfm_pkg::ST_OUT;
			dmfm_pkg::ST_OUT: begin
				if (out_free) state_d = dmfm_pkg::ST_IDLE;
			end
			default: state_d = dmfm_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: control outputs
	// ------------------------------------------------------------------
	logic in_take;
	logic calc_en;
	logic div_en;
	logic filt_en;
	logic out_load;

	always_comb begin
		s_tready = 1'b0;
		calc_en  = 1'b0;
		div_en   = 1'b0;
		filt_en  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			dmfm_pkg::ST_IDLE: s_tready = 1'b1;
			dmfm_pkg::ST_CALC: calc_en  = 1'b1;
			dmfm_pkg::ST_DIV:  div_en   = 1'b1;
			dmfm_pkg::ST_FILT: filt_en  = 1'b1;
			dmfm_pkg::ST_OUT:  out_load = out_free;
			default: ;
		endcase
	end

	assign in_take = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dmfm_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// ------------------------------------------------------------------
	// Datapath registers without reset
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_take) begin
			period_q <= s_tdata[31:0];
			now_q    <= s_tdata[63:32];
			cnt_q    <= s_tdata[79:64];
		end
		if (calc_en) begin
			// load divider operands for whichever method applies
			num_q  <= period_mode ? dmfm_pkg::PERIOD_NUM : gate_num;
			den_q  <= period_mode ? period_q : elapsed;
			rem_q  <= '0;
			dcnt_q <= dmfm_pkg::DIV_LAST;
			mode_q <= !period_mode;
			held_q <= 1'b0;
			// direct results carry no filter
			res_q  <= period_mode ? good_freq_q : cached_q;
		end
		if (div_en) begin
			rem_q  <= qbit ? trial_diff[dmfm_pkg::DIVS_W-1:0] : trial[dmfm_pkg::DIVS_W-1:0];
			num_q  <= {num_q[dmfm_pkg::DIVD_W-2:0], qbit};
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (filt_en) begin
			res_q  <= jump ? good_freq_q : cand;
			held_q <= jump;
		end
		if (out_load) begin
			m_freq_q <= res_q;
			m_held_q <= held_q;
			m_mode_q <= mode_q;
		end
	end

	// ------------------------------------------------------------------
	// Meter state and output valid
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_freq_q <= '0;
			cached_q    <= '0;
			gate_ms_q   <= '0;
			gate_cnt_q  <= '0;
			gate_div_q  <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (calc_en) begin
				gate_div_q <= !period_mode && calc_to_div;
				// overage restarts the gate without a new count
				if (!period_mode && gate_over) begin
					gate_ms_q  <= now_q;
					gate_cnt_q <= cnt_q;
				end
			end
			if (filt_en) begin
				// a finished gate refreshes the cached count and restarts
				if (gate_div_q) begin
					cached_q   <= quot_sat;
					gate_ms_q  <= now_q;
					gate_cnt_q <= cnt_q;
				end
				if (!jump && cand_live) good_freq_q <= cand;
			end
			if (out_load)      m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, m_freq_q};
	assign m_tuser  = {m_mode_q, m_held_q};

endmodule

// ----- hdl/dmfm_checker.sv -----
// Port-level checker for dual_mode_frequency_meter, bound to the top level.
// Depends on dmfm_pkg for the one-hertz threshold.
module dmfm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed under stall");

	// one word at a time: the block drops ready right after taking a word
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// a held result is a stored good value, which is always above one hertz
	a_held_live: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[27:0] > dmfm_pkg::ONE_HZ_Q8)
		else $error("held result at or below one hertz");

	// padding above the Q.8 value stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:28] == 4'd0)
		else $error("nonzero padding in result word");

endmodule

bind dual_mode_frequency_meter dmfm_checker u_dmfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
